/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dnlw_pkg.sv */
package dnlw_pkg;

    localparam int MAX_MESSAGE_BYTES_DEF = 512;
    localparam int MAX_WALK_STEPS_DEF    = 512;

    // Walk position: message offset plus one label jump.
    localparam int POS_W   = 15;
    localparam int PTR_W   = 14;
    localparam int PTR_HI_W = PTR_W - 8;

    localparam logic [1:0] PTR_MARK = 2'b11;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_STEPS = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        W_IDLE,
        W_STEP,
        W_BYTE,
        W_PTR,
        W_DONE
    } walk_state_t;

    typedef struct packed
    {
        logic       command;
        logic [7:0] byte_value;
        logic       is_last;
        logic [8:0] start_offset;
        logic [7:0] label_index;
    } in_item_t;

    typedef struct packed
    {
        logic [1:0] status;
        logic [7:0] label_count;
        logic       label_found;
        logic [8:0] label_offset;
    } out_item_t;

    typedef struct packed
    {
        cmd_t       kind;
        logic [7:0] byte_value;
        logic       is_last;
        logic [8:0] start_offset;
        logic [7:0] label_index;
    } op_t;

endpackage

/* hw/rtl/dns_name_label_walker_core.sv */
// Channel   Ports                 Handshake               Payload
// request   item, push, full      push & !full            dnlw_pkg::in_item_t
// result    result, empty, pop    pop & !empty            dnlw_pkg::out_item_t
//
// A load writes its byte as it is taken, staying idle; loads stream at one per
// cycle while no query walks. A query passes the queue, dispatch, STEP and BYTE
// per label plus PTR per compression pointer, the root byte and the result
// write; the walk is bounded by MAX_WALK_STEPS bytes examined.
// Reset clears the request queue, message length, write position and result slot.
// A full result slot holds the walker in its done state until pop; requests
// behind it wait in the queue, and full rises once two are queued.
module dns_name_label_walker_core
#(
    parameter int MAX_MESSAGE_BYTES = dnlw_pkg::MAX_MESSAGE_BYTES_DEF,
    parameter int MAX_WALK_STEPS    = dnlw_pkg::MAX_WALK_STEPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  dnlw_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output dnlw_pkg::out_item_t result
);

    logic          op_valid;
    logic          op_take;
    dnlw_pkg::op_t op;

    dnlw_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take)
    );

    dnlw_walker
    #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
        .MAX_WALK_STEPS    (MAX_WALK_STEPS)
    )
    u_walker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

/* hw/rtl/dnlw_front.sv */
module dnlw_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  dnlw_pkg::in_item_t item,
    output logic               op_valid,
    output dnlw_pkg::op_t      op,
    input  logic               op_take
);

    dnlw_pkg::op_t                   queue_reg [dnlw_pkg::QUEUE_DEPTH];
    logic [dnlw_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [dnlw_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [dnlw_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [dnlw_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [dnlw_pkg::QCNT_W-1:0]     count_reg;
    logic [dnlw_pkg::QCNT_W-1:0]     count_next;
    logic                            do_push;
    logic                            do_pop;
    dnlw_pkg::op_t                   classified;

    assign full     = (count_reg == dnlw_pkg::QCNT_W'(dnlw_pkg::QUEUE_DEPTH));
    assign op_valid = (count_reg != '0);
    assign op       = queue_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = op_take && op_valid;

    always_comb
    begin
        classified.kind         = item.command ? dnlw_pkg::CMD_QUERY : dnlw_pkg::CMD_LOAD;
        classified.byte_value   = item.byte_value;
        classified.is_last      = item.is_last;
        classified.start_offset = item.start_offset;
        classified.label_index  = item.label_index;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + dnlw_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + dnlw_pkg::QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + dnlw_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - dnlw_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

/* hw/rtl/dnlw_walker.sv */
module dnlw_walker
#(
    parameter int MAX_MESSAGE_BYTES = dnlw_pkg::MAX_MESSAGE_BYTES_DEF,
    parameter int MAX_WALK_STEPS    = dnlw_pkg::MAX_WALK_STEPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    input  dnlw_pkg::op_t       op,
    output logic                op_take,
    input  logic                pop,
    output logic                empty,
    output dnlw_pkg::out_item_t result
);

    localparam int ADDR_W = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
    localparam int LEN_W  = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int STEP_W = $clog2(MAX_WALK_STEPS + 1);
    localparam int POS_W  = dnlw_pkg::POS_W;
    localparam int PTR_W  = dnlw_pkg::PTR_W;
    localparam int HI_W   = dnlw_pkg::PTR_HI_W;

    logic [7:0]                store_mem [MAX_MESSAGE_BYTES];
    logic [7:0]                rd_data_reg;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;

    dnlw_pkg::walk_state_t     state_reg, state_next;
    logic [LEN_W-1:0]          wp_reg, wp_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic                      out_valid_reg, out_valid_next;
    dnlw_pkg::out_item_t       result_reg, result_next;

    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [8:0]                start_reg, start_next;
    logic [7:0]                want_reg, want_next;
    logic [7:0]                count_reg, count_next;
    logic [STEP_W-1:0]         steps_reg, steps_next;
    logic                      found_reg, found_next;
    logic [8:0]                found_at_reg, found_at_next;
    logic [HI_W-1:0]           hi_reg, hi_next;
    dnlw_pkg::status_t         status_reg, status_next;

    logic [LEN_W-1:0]          wp_after;
    logic [POS_W-1:0]          len_ext;
    logic [POS_W-1:0]          pos_plus1;
    logic [PTR_W-1:0]          target;

    assign len_ext   = POS_W'(len_reg);
    assign pos_plus1 = pos_reg + POS_W'(1);
    assign target    = {hi_reg, rd_data_reg};
    assign empty     = !out_valid_reg;
    assign result    = result_reg;
    assign wr_addr   = wp_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        want_next     = want_reg;
        count_next    = count_reg;
        steps_next    = steps_reg;
        found_next    = found_reg;
        found_at_next = found_at_reg;
        hi_next       = hi_reg;
        status_next   = status_reg;
        result_next   = result_reg;
        out_valid_next = (pop && out_valid_reg) ? 1'b0 : out_valid_reg;
        op_take       = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = pos_reg[ADDR_W-1:0];
        wr_en         = 1'b0;
        wp_after      = wp_reg;

        case (state_reg)
            dnlw_pkg::W_IDLE:
            begin
                if (op_valid)
                begin
                    op_take = 1'b1;
                    if (op.kind == dnlw_pkg::CMD_LOAD)
                    begin
                        if (wp_reg < LEN_W'(MAX_MESSAGE_BYTES))
                        begin
                            wr_en    = 1'b1;
                            wp_after = wp_reg + LEN_W'(1);
                        end
                        if (op.is_last)
                        begin
                            len_next = wp_after;
                            wp_next  = '0;
                        end
                        else
                        begin
                            wp_next = wp_after;
                        end
                    end
                    else
                    begin
                        pos_next      = POS_W'(op.start_offset);
                        start_next    = op.start_offset;
                        want_next     = op.label_index;
                        count_next    = '0;
                        steps_next    = '0;
                        found_next    = 1'b0;
                        found_at_next = '0;
                        status_next   = dnlw_pkg::ST_OK;
                        state_next    = dnlw_pkg::W_STEP;
                    end
                end
            end

            dnlw_pkg::W_STEP:
            begin
                if (steps_reg == STEP_W'(MAX_WALK_STEPS))
                begin
                    status_next = dnlw_pkg::ST_STEPS;
                    state_next  = dnlw_pkg::W_DONE;
                end
                else
                begin
                    steps_next = steps_reg + STEP_W'(1);
                    if (pos_reg >= len_ext)
                    begin
                        status_next = dnlw_pkg::ST_BAD;
                        state_next  = dnlw_pkg::W_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = dnlw_pkg::W_BYTE;
                    end
                end
            end

            dnlw_pkg::W_BYTE:
            begin
                if (rd_data_reg == 8'd0)
                begin
                    state_next = dnlw_pkg::W_DONE;
                end
                else if (rd_data_reg[7:6] == dnlw_pkg::PTR_MARK)
                begin
                    if (pos_plus1 >= len_ext)
                    begin
                        status_next = dnlw_pkg::ST_BAD;
                        state_next  = dnlw_pkg::W_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = pos_plus1[ADDR_W-1:0];
                        hi_next    = rd_data_reg[HI_W-1:0];
                        state_next = dnlw_pkg::W_PTR;
                    end
                end
                else
                begin
                    if (!found_reg && (count_reg == want_reg))
                    begin
                        found_next    = 1'b1;
                        found_at_next = pos_reg[8:0];
                    end
                    pos_next = pos_reg + POS_W'(rd_data_reg) + POS_W'(1);
                    if (count_reg != 8'hff)
                    begin
                        count_next = count_reg + 8'd1;
                    end
                    state_next = dnlw_pkg::W_STEP;
                end
            end

            dnlw_pkg::W_PTR:
            begin
                if (target >= PTR_W'(start_reg))
                begin
                    status_next = dnlw_pkg::ST_BAD;
                    state_next  = dnlw_pkg::W_DONE;
                end
                else
                begin
                    pos_next   = POS_W'(target);
                    state_next = dnlw_pkg::W_STEP;
                end
            end

            dnlw_pkg::W_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    result_next.status       = status_reg;
                    result_next.label_count  = (status_reg == dnlw_pkg::ST_OK) ? count_reg : 8'd0;
                    result_next.label_found  = found_reg;
                    result_next.label_offset = found_reg ? found_at_reg : 9'd0;
                    out_valid_next           = 1'b1;
                    state_next               = dnlw_pkg::W_IDLE;
                end
            end

            default:
            begin
                state_next = dnlw_pkg::W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dnlw_pkg::W_IDLE;
            wp_reg        <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        start_reg    <= start_next;
        want_reg     <= want_next;
        count_reg    <= count_next;
        steps_reg    <= steps_next;
        found_reg    <= found_next;
        found_at_reg <= found_at_next;
        hi_reg       <= hi_next;
        status_reg   <= status_next;
        result_reg   <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= op.byte_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/dnlw_checker.sv */
`include "assert_macros.svh"

module dnlw_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input dnlw_pkg::out_item_t result
);

    logic shown_err;
    logic shown_absent;

    assign shown_err    = !empty && (result.status != dnlw_pkg::ST_OK);
    assign shown_absent = !empty && !result.label_found;

    `CHK_SAME(a_status_code, !empty, result.status <= dnlw_pkg::ST_STEPS, "status out of range")
    `CHK_SAME(a_err_count, shown_err, result.label_count == '0, "nonzero count on error")
    `CHK_SAME(a_absent_offset, shown_absent, result.label_offset == '0, "offset for absent label")
    `CHK_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result), "result not held")

endmodule

bind dns_name_label_walker_core dnlw_checker u_dnlw_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
